// ===== sv/qnm_pkg.sv =====
// qnm_pkg: shared types and constants of the quaternion to rotation matrix block
// used by the front, queue, back and top level modules
package qnm_pkg;

  localparam int NumLanes = 9;   // matrix entries
  localparam int CompW    = 16;  // quaternion component width
  localparam int MagW     = 33;  // magnitude of numerator and squared norm
  localparam int NumW     = 34;  // signed numerator width
  localparam int QuoW     = 15;  // quotient bits, result at most 16384
  localparam int RemW     = 49;  // running remainder of the divider
  localparam int DivW     = 34;  // divisor, twice the squared norm

  localparam logic [2:0] AddrThreshold = 3'd0;

  // one classified item between front and back
  typedef struct packed {
    logic                               zero;
    logic [NumLanes-1:0]                neg;
    logic [NumLanes-1:0][MagW-1:0]      mag;
    logic [MagW-1:0]                    norm;
  } entry_t;

endpackage

// ===== sv/qnm_front.sv =====
// qnm_front: accepts raw quaternions, forms products, squared norm and numerators
// and classifies each item against the zero threshold; depends on qnm_pkg
module qnm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [63:0]          in_data_i,
  input  logic [31:0]          threshold_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qnm_pkg::entry_t      out_entry_o
);
  import qnm_pkg::*;

  logic en;
  logic v1_q, v2_q, v3_q;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic [MagW-1:0] n2_q;
  logic signed [NumW-1:0] num_q [NumLanes];
  entry_t ent_q;
  logic signed [CompW-1:0] w, x, y, z;

  assign w = in_data_i[15:0];
  assign x = in_data_i[31:16];
  assign y = in_data_i[47:32];
  assign z = in_data_i[63:48];

  // whole front moves when its last stage can hand off
  assign en          = !v3_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v3_q;
  assign out_entry_o = ent_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // products
  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= w * w;
      xx_q <= x * x;
      yy_q <= y * y;
      zz_q <= z * z;
      xy_q <= x * y;
      wz_q <= w * z;
      xz_q <= x * z;
      wy_q <= w * y;
      yz_q <= y * z;
      wx_q <= w * x;
    end
  end

  // squared norm and signed numerators
  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q <= MagW'(ww_q) + MagW'(xx_q) + MagW'(yy_q) + MagW'(zz_q);
      num_q[0] <= NumW'(ww_q) + NumW'(xx_q) - NumW'(yy_q) - NumW'(zz_q);
      num_q[1] <= (NumW'(xy_q) - NumW'(wz_q)) <<< 1;
      num_q[2] <= (NumW'(xz_q) + NumW'(wy_q)) <<< 1;
      num_q[3] <= (NumW'(xy_q) + NumW'(wz_q)) <<< 1;
      num_q[4] <= NumW'(ww_q) - NumW'(xx_q) + NumW'(yy_q) - NumW'(zz_q);
      num_q[5] <= (NumW'(yz_q) - NumW'(wx_q)) <<< 1;
      num_q[6] <= (NumW'(xz_q) - NumW'(wy_q)) <<< 1;
      num_q[7] <= (NumW'(yz_q) + NumW'(wx_q)) <<< 1;
      num_q[8] <= NumW'(ww_q) - NumW'(xx_q) - NumW'(yy_q) + NumW'(zz_q);
    end
  end

  // sign and magnitude split, zero check
  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q.norm <= n2_q;
      ent_q.zero <= n2_q <= {1'b0, threshold_i};
      for (int i = 0; i < NumLanes; i++) begin
        ent_q.neg[i] <= num_q[i][NumW-1];
        ent_q.mag[i] <= num_q[i][NumW-1] ? MagW'(-num_q[i]) : MagW'(num_q[i]);
      end
    end
  end

endmodule

// ===== sv/qnm_queue.sv =====
// qnm_queue: two-entry queue between front and back so each side stalls alone
// depends on qnm_pkg for the entry type
module qnm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qnm_pkg::entry_t  push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output qnm_pkg::entry_t  head_o
);
  import qnm_pkg::*;

  entry_t    mem_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_entry_i;
  end

endmodule

// ===== sv/qnm_back.sv =====
// qnm_back: pipelined restoring divider, one quotient bit per stage in nine lanes,
// then sign, zero handling and the output register; depends on qnm_pkg
module qnm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  qnm_pkg::entry_t              in_entry_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [qnm_pkg::NumLanes*16-1:0] out_data_o,
  output logic                         out_zero_o
);
  import qnm_pkg::*;

  localparam int NumStg = QuoW + 1;

  logic en;
  logic               v_q    [NumStg];
  logic               zero_q [NumStg];
  logic [NumLanes-1:0] neg_q [NumStg];
  logic [DivW-1:0]    d_q    [NumStg];
  logic [RemW-1:0]    rem_q  [NumStg][NumLanes];
  logic [QuoW-1:0]    quo_q  [NumStg][NumLanes];
  logic               vout_q;
  logic               zout_q;
  logic [NumLanes*16-1:0] dout_q;

  // pipeline moves when the output register is free or drained
  assign en          = !vout_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vout_q;
  assign out_data_o  = dout_q;
  assign out_zero_o  = zout_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumStg; s++) v_q[s] <= 1'b0;
      vout_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int s = 1; s < NumStg; s++) v_q[s] <= v_q[s-1];
      vout_q <= v_q[NumStg-1];
    end
  end

  // load: dividend is mag*2^15 + n, divisor 2n
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q[0] <= in_entry_i.zero;
      neg_q[0]  <= in_entry_i.neg;
      d_q[0]    <= {in_entry_i.norm, 1'b0};
      for (int i = 0; i < NumLanes; i++) begin
        rem_q[0][i] <= (RemW'(in_entry_i.mag[i]) << QuoW) + RemW'(in_entry_i.norm);
        quo_q[0][i] <= '0;
      end
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s < NumStg; s++) begin : g_stg
    localparam int Bit = QuoW - s;
    logic [RemW-1:0] dsh;
    assign dsh = RemW'(d_q[s-1]) << Bit;
    always_ff @(posedge clk_i) begin
      if (en) begin
        zero_q[s] <= zero_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        d_q[s]    <= d_q[s-1];
        for (int i = 0; i < NumLanes; i++) begin
          if (rem_q[s-1][i] >= dsh) begin
            rem_q[s][i] <= rem_q[s-1][i] - dsh;
            quo_q[s][i] <= quo_q[s-1][i] | (QuoW'(1) << Bit);
          end else begin
            rem_q[s][i] <= rem_q[s-1][i];
            quo_q[s][i] <= quo_q[s-1][i];
          end
        end
      end
    end
  end

  // sign, zero case, output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      zout_q <= zero_q[NumStg-1];
      for (int i = 0; i < NumLanes; i++) begin
        if (zero_q[NumStg-1]) begin
          dout_q[i*16 +: 16] <= '0;
        end else if (neg_q[NumStg-1][i]) begin
          dout_q[i*16 +: 16] <= 16'(-{1'b0, quo_q[NumStg-1][i]});
        end else begin
          dout_q[i*16 +: 16] <= {1'b0, quo_q[NumStg-1][i]};
        end
      end
    end
  end

endmodule

// ===== sv/quaternion_normalize_to_matrix.sv =====
// quaternion_normalize_to_matrix: top level, stream ports and threshold register
// instantiates qnm_front, qnm_queue and qnm_back; depends on qnm_pkg
//
// Usage:
//   s_axis: one raw quaternion per beat, tdata = {z, y, x, w}, w in the low bits.
//   m_axis: one result beat per input beat, in order; tdata holds r11..r33,
//     r11 in the low bits, each signed Q2.14; tuser is the zero-magnitude flag,
//     set with an all-zero matrix when w*w+x*x+y*y+z*z <= zero_threshold.
//   APB: zero_threshold at byte address 0; write it only while the block is idle.
// Pipeline: 3 front stages, the queue register, a load stage and 15 divider stages,
//   then the output register between input beat and output beat.
// Throughput: one beat per cycle when not stalled; the 15-stage pipelined divider
//   (one quotient bit per stage across nine lanes) sets the latency, not the rate.
// Reset: all pipelines and the queue empty, threshold 0.
// Stall: when m_axis_tready is low the back pipeline holds; the two-entry queue
//   absorbs front output until it fills, then s_axis_tready drops.
module quaternion_normalize_to_matrix (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // in_w, in_x, in_y, in_z
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // r11, r12, r13, r21, r22, r23, r31, r32, r33
  output logic          m_axis_tuser,   // zero_error
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import qnm_pkg::*;

  logic [31:0] thr_q;
  logic        fr_valid, fr_ready, q_full, q_empty, bk_ready;
  entry_t      fr_entry, q_head;

  // threshold register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == AddrThreshold[2]) ? thr_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == AddrThreshold[2]) begin
      thr_q <= pwdata;
    end
  end

  qnm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .threshold_i (thr_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_entry_o (fr_entry)
  );

  assign fr_ready = !q_full;

  qnm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fr_valid && !q_full),
    .push_entry_i (fr_entry),
    .full_o       (q_full),
    .pop_i        (bk_ready && !q_empty),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  qnm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_empty),
    .in_ready_o  (bk_ready),
    .in_entry_i  (q_head),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_zero_o  (m_axis_tuser)
  );

endmodule

// ===== sim/tb_quaternion_normalize_to_matrix.sv =====
// tb_quaternion_normalize_to_matrix: self-checking bench for the quaternion to matrix block
// drives the stream and apb ports and checks every result beat; depends on qnm_pkg and the rtl
module tb_quaternion_normalize_to_matrix;
  import qnm_pkg::*;

  typedef struct packed {
    logic        zero_err;
    logic [143:0] mat;
  } matrix_beat_t;

  typedef struct {
    logic [15:0]  w, x, y, z;
    logic         has_golden;
    matrix_beat_t golden;
  } quat_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [63:0]   s_axis_tdata = '0;   // in_w, in_x, in_y, in_z
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [143:0]  m_axis_tdata;        // r11, r12, r13, r21, r22, r23, r31, r32, r33
  logic          m_axis_tuser;        // zero_error
  logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  quaternion_normalize_to_matrix dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0]  zero_thresh = '0;
  matrix_beat_t pending_mats[$];
  int unsigned  fail_cnt = 0;
  int unsigned  cycle_cnt = 0;
  bit           calm_phase = 1'b0;   // no idling near the end
  bit           hold_sink = 1'b0;    // long receiver hold-off
  quat_row_t    directed[$];

  // round(num * 2^14 / n), ties away from zero
  function automatic logic [15:0] q14_ratio(longint num, longint unsigned n);
    longint unsigned mag, q;
    longint r;
    mag = (num < 0) ? longint'(-num) : num;
    q = ((mag << 15) + n) / (n << 1);
    r = (num < 0) ? -longint'(q) : longint'(q);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic matrix_beat_t rotation_of(logic [15:0] qw, logic [15:0] qx,
                                               logic [15:0] qy, logic [15:0] qz);
    longint w, x, y, z, xx, yy, zz, sn;
    longint unsigned n;
    matrix_beat_t m;
    w = longint'($signed(qw)); x = longint'($signed(qx));
    y = longint'($signed(qy)); z = longint'($signed(qz));
    xx = x * x; yy = y * y; zz = z * z;
    sn = w * w + xx + yy + zz;
    n = sn;
    m = '0;
    if (n <= zero_thresh) begin
      m.zero_err = 1'b1;
      return m;
    end
    m.mat[15:0]    = q14_ratio(sn - 2 * (yy + zz), n);
    m.mat[31:16]   = q14_ratio(2 * (x * y - w * z), n);
    m.mat[47:32]   = q14_ratio(2 * (x * z + w * y), n);
    m.mat[63:48]   = q14_ratio(2 * (x * y + w * z), n);
    m.mat[79:64]   = q14_ratio(sn - 2 * (xx + zz), n);
    m.mat[95:80]   = q14_ratio(2 * (y * z - w * x), n);
    m.mat[111:96]  = q14_ratio(2 * (x * z - w * y), n);
    m.mat[127:112] = q14_ratio(2 * (y * z + w * x), n);
    m.mat[143:128] = q14_ratio(sn - 2 * (xx + yy), n);
    return m;
  endfunction

  // apb write, setup then access
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    zero_thresh = data;
  endtask

  // one input beat, with random gaps before it
  task automatic send_quat(logic [15:0] w, x, y, z);
    int gap;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_mats.push_back(rotation_of(w, x, y, z));
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stall bursts, or a long hold-off
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14);
        m_axis_tready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    matrix_beat_t exp_m;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_mats.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_cnt++;
      end else begin
        exp_m = pending_mats.pop_front();
        for (int k = 0; k < NumLanes; k++)
          if (m_axis_tdata[16*k +: 16] !== exp_m.mat[16*k +: 16]) begin
            $error("r%0d%0d expected %h actual %h", k / 3 + 1, k % 3 + 1,
                   exp_m.mat[16*k +: 16], m_axis_tdata[16*k +: 16]);
            fail_cnt++;
          end
        if (m_axis_tuser !== exp_m.zero_err) begin
          $error("zero_error expected %b actual %b", exp_m.zero_err, m_axis_tuser);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 400000) begin
      $display("tb_quaternion_normalize_to_matrix failed");
      $finish;
    end
  end

  function automatic void add_row(logic [15:0] w, x, y, z, bit g = 0,
                                  matrix_beat_t gm = '0);
    quat_row_t r;
    r.w = w; r.x = x; r.y = y; r.z = z; r.has_golden = g; r.golden = gm;
    directed.push_back(r);
  endfunction

  initial begin
    matrix_beat_t ident, zero_m, flip;
    logic [15:0] w, x, y, z;
    ident = '0; ident.mat[15:0] = 16'h4000; ident.mat[79:64] = 16'h4000;
    ident.mat[143:128] = 16'h4000;
    zero_m = '0; zero_m.zero_err = 1'b1;
    // rotation by pi about x: diag(1,-1,-1)
    flip = '0; flip.mat[15:0] = 16'h4000; flip.mat[79:64] = 16'hc000;
    flip.mat[143:128] = 16'hc000;

    // directed table
    add_row(0, 0, 0, 0, 1, zero_m);
    add_row(1, 0, 0, 0, 1, ident);
    add_row(16'h7fff, 0, 0, 0, 1, ident);
    add_row(16'h8000, 0, 0, 0, 1, ident);
    add_row(0, 16'h7fff, 0, 0, 1, flip);
    add_row(0, 16'h8000, 0, 0, 1, flip);
    add_row(0, 0, 16'h8000, 0);
    add_row(0, 0, 0, 16'h7fff);
    add_row(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_row(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    add_row(1, 1, 1, 1);
    add_row(1, 2, 3, 4);
    add_row(16'hffff, 16'hffff, 0, 1);
    add_row(3, 16'hfffd, 5, 16'hfff9);
    add_row(16'h5555, 16'haaaa, 16'h1234, 16'hedcb);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_quat(directed[i].w, directed[i].x, directed[i].y, directed[i].z);
      if (directed[i].has_golden && rotation_of(directed[i].w, directed[i].x,
          directed[i].y, directed[i].z) != directed[i].golden) begin
        $error("table row %0d expected %h", i, directed[i].golden);
        fail_cnt++;
      end
    end
    // sender pause until everything is back
    drain_all();

    // threshold settings, extremes among them
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: apb_write(AddrThreshold, 32'd3);
        1: apb_write(AddrThreshold, 32'($urandom));
        2: apb_write(AddrThreshold, 32'hffff_ffff);
        3: apb_write(AddrThreshold, 32'd1 << $urandom_range(0, 31));
        default: apb_write(AddrThreshold, 32'd0);
      endcase
      if (phase == 1) hold_sink = 1'b1;
      if (phase == 4) calm_phase = 1'b1;
      for (int i = 0; i < 320; i++) begin
        w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
        if ($urandom_range(0, 15) == 0) begin
          w = 16'($urandom_range(0, 4)) - 16'd2; x = 0; y = 0; z = 0;
        end
        send_quat(w, x, y, z);
      end
      drain_all();
    end

    if (fail_cnt == 0) begin
      $display("tb_quaternion_normalize_to_matrix passed");
    end else begin
      $display("tb_quaternion_normalize_to_matrix failed");
    end
    $finish;
  end
endmodule
